// ===== hdl/multi_led_flash_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// multi led flash controller assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef MULTI_LED_FLASH_CONTROLLER_UNIT_DEFINES_SVH
`define MULTI_LED_FLASH_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define MLFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define MLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mlfc_pkg.sv =====
// ---------------------------------------------------------------------------
// mlfc package
// payload types, constants and codes of the led flash controller
// ---------------------------------------------------------------------------
package mlfc_pkg;

  localparam int LED_MAX          = 8;
  localparam int LED_COUNT_DEF    = 8;
  localparam int MS_PER_UNIT_DEF  = 50;
  localparam int CNT_W            = 14;
  localparam int MIN_FRAME_LEN    = 3;
  localparam int PERIOD_FRAME_LEN = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ADDR   = 3'd0,
    CFG_BCAST_ADDR  = 3'd1,
    CFG_CMD_ID      = 3'd2,
    CFG_STATUS_ID   = 3'd3,
    CFG_ACTIVE_HIGH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        command;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  target_node;
    logic [7:0]  led_mask;
    logic [7:0]  led_request;
    logic [7:0]  flash_period;
  } in_t;

  typedef struct packed {
    logic [7:0]  pin_levels;
    logic        status_valid;
    logic [10:0] status_frame;
    logic [7:0]  status_node;
    logic [7:0]  status_bitmap;
  } out_t;

  // per-beat command broadcast to every led slot
  typedef struct packed {
    logic             tick;
    logic             frame_ok;
    logic [CNT_W-1:0] half;
  } slot_cmd_t;

endpackage

// ===== hdl/mlfc_slot.sv =====
// ---------------------------------------------------------------------------
// mlfc led slot
// mode, phase and countdown of one led
// ---------------------------------------------------------------------------
module mlfc_slot
  import mlfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  slot_cmd_t cmd_i,
  input  logic      sel_i,
  input  logic      req_i,
  output logic      lit_o,
  output logic      active_o
);

  logic             active_q, active_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] interval_q, interval_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_dec;

  assign count_dec = (count_q != '0) ? count_q - CNT_W'(1) : count_q;

  always_comb begin
    active_d   = active_q;
    phase_d    = phase_q;
    interval_d = interval_q;
    count_d    = count_q;
    if (cmd_i.tick) begin
      if (interval_q != '0) begin
        if (count_dec == '0) begin
          phase_d = ~phase_q;
          count_d = interval_q;
        end else begin
          count_d = count_dec;
        end
      end
    end else if (cmd_i.frame_ok && sel_i) begin
      if (!req_i) begin
        interval_d = '0;
        active_d   = 1'b0;
      end else if (cmd_i.half == '0) begin
        interval_d = '0;
        active_d   = 1'b1;
      end else begin
        interval_d = cmd_i.half;
        phase_d    = 1'b1;
        count_d    = cmd_i.half;
        active_d   = 1'b1;
      end
    end
  end

  // levels seen after this beat's update
  assign lit_o    = active_d && ((interval_d == '0) || phase_d);
  assign active_o = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      phase_q    <= 1'b0;
      interval_q <= '0;
      count_q    <= '0;
    end else if (en_i) begin
      active_q   <= active_d;
      phase_q    <= phase_d;
      interval_q <= interval_d;
      count_q    <= count_d;
    end
  end

endmodule

// ===== hdl/multi_led_flash_controller_unit.sv =====
// ---------------------------------------------------------------------------
// multi led flash controller unit
// drives up to eight leds from command frames and millisecond ticks
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o / in_data_i, one beat per command
//   frame (command 0) or per millisecond tick (command 1)
//   output channel: out_valid_o / out_stall_i / out_data_o, exactly one beat
//   per input beat, in order: pin levels, plus the status reply fields when a
//   frame was accepted (zero otherwise)
//   configuration: cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i, always
//   ready; write only while the block is idle
//   latency: a beat taken at one edge shows on the output after the next edge
//   throughput: one beat per cycle, set by the single input register feeding
//   the led slots and the result register
//   reset: registers to their defaults (broadcast 255, active-high drive), all
//   leds off, both stages empty
//   stall: the result register holds; the input stage fills and then
//   in_stall_o rises until the receiver takes the waiting beat
// ---------------------------------------------------------------------------
module multi_led_flash_controller_unit
  import mlfc_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int MS_PER_UNIT = MS_PER_UNIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // leds that really exist
  localparam logic [LED_MAX-1:0] LedBits = LED_MAX'((1 << LED_COUNT) - 1);

  // configuration registers
  logic [7:0]  node_addr_q;
  logic [7:0]  bcast_addr_q;
  logic [10:0] cmd_id_q;
  logic [10:0] status_id_q;
  logic        active_high_q;

  // pipeline registers
  logic        s1_valid_q;
  in_t         s1_data_q;
  logic        out_valid_q;
  out_t        out_data_q;

  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  logic             addr_hit;
  logic             frame_ok;
  logic [CNT_W-1:0] period_ms;
  slot_cmd_t        slot_cmd;
  logic [LED_MAX-1:0] sel_mask;
  logic [LED_MAX-1:0] lit_w;
  logic [LED_MAX-1:0] active_w;
  logic [LED_MAX-1:0] pins;
  out_t        result;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q   <= 8'd0;
      bcast_addr_q  <= 8'd255;
      cmd_id_q      <= 11'd0;
      status_id_q   <= 11'd0;
      active_high_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NODE_ADDR:   node_addr_q   <= cfg_data_i[7:0];
        CFG_BCAST_ADDR:  bcast_addr_q  <= cfg_data_i[7:0];
        CFG_CMD_ID:      cmd_id_q      <= cfg_data_i[10:0];
        CFG_STATUS_ID:   status_id_q   <= cfg_data_i[10:0];
        CFG_ACTIVE_HIGH: active_high_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // the result register frees up when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  // ------------------------------------------------------- frame decoding
  assign addr_hit = (s1_data_q.target_node == node_addr_q) ||
                    (s1_data_q.target_node == bcast_addr_q);

  assign frame_ok = !s1_data_q.command &&
                    (s1_data_q.frame_id == cmd_id_q) &&
                    (s1_data_q.frame_len >= 4'(MIN_FRAME_LEN)) &&
                    addr_hit;

  // half period in ms; a zero period byte gives zero, meaning solid
  assign period_ms = CNT_W'(s1_data_q.flash_period) * CNT_W'(MS_PER_UNIT);

  assign slot_cmd.tick     = s1_data_q.command;
  assign slot_cmd.frame_ok = frame_ok;
  assign slot_cmd.half     = (s1_data_q.frame_len >= 4'(PERIOD_FRAME_LEN)) ?
                             period_ms : '0;

  assign sel_mask = s1_data_q.led_mask & LedBits;

  // ------------------------------------------------------------ led slots
  for (genvar g = 0; g < LED_MAX; g++) begin : g_led
    if (g < LED_COUNT) begin : g_slot
      mlfc_slot u_slot (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (s1_fire),
        .cmd_i    (slot_cmd),
        .sel_i    (sel_mask[g]),
        .req_i    (s1_data_q.led_request[g]),
        .lit_o    (lit_w[g]),
        .active_o (active_w[g])
      );
    end else begin : g_none
      assign lit_w[g]    = 1'b0;
      assign active_w[g] = 1'b0;
    end
  end

  // polarity applies to existing leds only
  assign pins = (active_high_q ? lit_w : ~lit_w) & LedBits;

  // ---------------------------------------------------------------- result
  always_comb begin
    result.pin_levels    = pins;
    result.status_valid  = frame_ok;
    result.status_frame  = frame_ok ? status_id_q : 11'd0;
    result.status_node   = frame_ok ? node_addr_q : 8'd0;
    result.status_bitmap = frame_ok ? active_w : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/mlfc_checker.sv =====
// ---------------------------------------------------------------------------
// mlfc checker
// port-level checks of the led flash controller, bound to the top level
// ---------------------------------------------------------------------------
`include "multi_led_flash_controller_unit_defines.svh"

module mlfc_checker
  import mlfc_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  localparam logic [LED_MAX-1:0] LedBits = LED_MAX'((1 << LED_COUNT) - 1);

  `MLFC_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result beat dropped while stalled")

  `MLFC_ASSERT_NEXT(a_out_data_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "result beat changed while stalled")

  // no reply fields without an accepted frame
  `MLFC_ASSERT_IMPLY(a_status_quiet, clk_i, rst_ni, out_valid_o && !out_data_o.status_valid, (out_data_o.status_frame == 11'd0) && (out_data_o.status_node == 8'd0) && (out_data_o.status_bitmap == 8'd0), "status fields set without a reply")

  // leds beyond the configured count never show
  `MLFC_ASSERT_IMPLY(a_unused_leds_low, clk_i, rst_ni, out_valid_o, ((out_data_o.pin_levels & ~LedBits) == '0) && ((out_data_o.status_bitmap & ~LedBits) == '0), "unused led bit set")

endmodule

bind multi_led_flash_controller_unit mlfc_checker #(
  .LED_COUNT (LED_COUNT)
) u_mlfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/tb_multi_led_flash_controller_unit.sv =====
// ---------------------------------------------------------------------------
// multi led flash controller unit testbench
// drives command frames and millisecond ticks through the stall handshake,
// predicts each result beat with a behavioural led model or takes a typed-in
// one, and compares each field of each result beat in arrival order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_led_flash_controller_unit;
  import mlfc_pkg::*;

  // one directed row: the beat, and a typed-in result where it is obvious
  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t want;
  } plan_row_t;

  localparam int PLAN_LEN = 16;
  localparam int PHASE_ITEMS = 156;
  localparam logic [7:0] LED_BITS = 8'((1 << LED_COUNT_DEF) - 1);

  // directed table, reset register values (node 0, broadcast ff, ids 0, active high)
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // tick straight after reset, everything dark
    '{in_t'{1'b1, 11'h000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      out_t'{8'h00, 1'b0, 11'h000, 8'h00, 8'h00}},
    // all leds solid on, shortest valid frame
    '{in_t'{1'b0, 11'h000, 4'd3, 8'h00, 8'hff, 8'hff, 8'h00}, 1'b1,
      out_t'{8'hff, 1'b1, 11'h000, 8'h00, 8'hff}},
    // wrong identifier is dropped
    '{in_t'{1'b0, 11'h7ff, 4'd3, 8'h00, 8'hff, 8'h00, 8'h00}, 1'b1,
      out_t'{8'hff, 1'b0, 11'h000, 8'h00, 8'h00}},
    // too short is dropped
    '{in_t'{1'b0, 11'h000, 4'd2, 8'h00, 8'hff, 8'h00, 8'h00}, 1'b1,
      out_t'{8'hff, 1'b0, 11'h000, 8'h00, 8'h00}},
    // foreign target is dropped
    '{in_t'{1'b0, 11'h000, 4'd3, 8'h55, 8'hff, 8'h00, 8'h00}, 1'b1,
      out_t'{8'hff, 1'b0, 11'h000, 8'h00, 8'h00}},
    // broadcast target turns the low nibble off
    '{in_t'{1'b0, 11'h000, 4'd3, 8'hff, 8'h0f, 8'h00, 8'h00}, 1'b1,
      out_t'{8'hf0, 1'b1, 11'h000, 8'h00, 8'hf0}},
    // led 0 flashing at the shortest period, starts lit
    '{in_t'{1'b0, 11'h000, 4'd4, 8'h00, 8'h01, 8'h01, 8'h01}, 1'b1,
      out_t'{8'hf1, 1'b1, 11'h000, 8'h00, 8'hf1}},
    // length over eight, longest period on led 1
    '{in_t'{1'b0, 11'h000, 4'd15, 8'h00, 8'h02, 8'h02, 8'hff}, 1'b1,
      out_t'{8'hf3, 1'b1, 11'h000, 8'h00, 8'hf3}},
    // period byte ignored at length three, so led 2 is solid
    '{in_t'{1'b0, 11'h000, 4'd3, 8'h00, 8'h04, 8'h04, 8'h05}, 1'b1,
      out_t'{8'hf7, 1'b1, 11'h000, 8'h00, 8'hf7}},
    // tick with every other field high
    '{in_t'{1'b1, 11'h7ff, 4'd15, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, out_t'('0)},
    // everything off
    '{in_t'{1'b0, 11'h000, 4'd8, 8'h00, 8'hff, 8'h00, 8'hff}, 1'b1,
      out_t'{8'h00, 1'b1, 11'h000, 8'h00, 8'h00}},
    // period zero at length four means solid
    '{in_t'{1'b0, 11'h000, 4'd4, 8'hff, 8'h80, 8'h80, 8'h00}, 1'b1,
      out_t'{8'h80, 1'b1, 11'h000, 8'h00, 8'h80}},
    // empty frame is dropped
    '{in_t'{1'b0, 11'h000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      out_t'{8'h80, 1'b0, 11'h000, 8'h00, 8'h00}},
    // accepted frame with an empty mask changes nothing but still replies
    '{in_t'{1'b0, 11'h000, 4'd3, 8'h00, 8'h00, 8'hff, 8'h00}, 1'b1,
      out_t'{8'h80, 1'b1, 11'h000, 8'h00, 8'h80}},
    // mixed off and flashing
    '{in_t'{1'b0, 11'h000, 4'd9, 8'h00, 8'hff, 8'haa, 8'h02}, 1'b0, out_t'('0)},
    '{in_t'{1'b1, 11'h000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, out_t'('0)}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // register shadow, reset values
  logic [7:0]  cfg_node = 8'd0;
  logic [7:0]  cfg_bcast = 8'hff;
  logic [10:0] cfg_cmd_id = 11'd0;
  logic [10:0] cfg_stat_id = 11'd0;
  logic        cfg_high = 1'b1;

  // led state shadow
  logic [7:0]       on_map = 8'h00;
  logic [CNT_W-1:0] half_ms [LED_COUNT_DEF] = '{default: '0};
  logic             blink_ph [LED_COUNT_DEF] = '{default: 1'b0};
  logic [CNT_W-1:0] ms_left [LED_COUNT_DEF] = '{default: '0};

  out_t due_replies [$];
  int   mismatch_cnt = 0;
  bit   calm = 1'b0;   // set for a stretch with no gaps and no stalls

  multi_led_flash_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // behavioural led model: advance the shadow state by one beat and return
  // the result beat it should produce
  // ---------------------------------------------------------------------------
  function automatic out_t step_leds(in_t b);
    out_t             r;
    logic [7:0]       lit;
    logic [CNT_W-1:0] half;
    int unsigned      span;
    logic             taken;
    r = '0;
    taken = 1'b0;
    if (b.command) begin
      // tick: count down flashing leds, toggle on expiry (also when already zero)
      for (int i = 0; i < LED_COUNT_DEF; i++) begin
        if (half_ms[i] == '0) continue;
        if (ms_left[i] != '0) ms_left[i] = ms_left[i] - 1'b1;
        if (ms_left[i] == '0) begin
          blink_ph[i] = ~blink_ph[i];
          ms_left[i] = half_ms[i];
        end
      end
    end else if (b.frame_id == cfg_cmd_id && b.frame_len >= MIN_FRAME_LEN &&
                 (b.target_node == cfg_node || b.target_node == cfg_bcast)) begin
      taken = 1'b1;
      span = b.flash_period * MS_PER_UNIT_DEF;
      half = (b.frame_len >= PERIOD_FRAME_LEN && b.flash_period != 8'd0) ?
             span[CNT_W-1:0] : '0;
      for (int i = 0; i < LED_COUNT_DEF; i++) begin
        if (!b.led_mask[i]) continue;
        if (!b.led_request[i]) begin
          half_ms[i] = '0;
          on_map[i] = 1'b0;
        end else if (half == '0) begin
          half_ms[i] = '0;
          on_map[i] = 1'b1;
        end else begin
          half_ms[i] = half;
          blink_ph[i] = 1'b1;
          ms_left[i] = half;
          on_map[i] = 1'b1;
        end
      end
    end
    lit = 8'h00;
    for (int i = 0; i < LED_COUNT_DEF; i++) begin
      if (on_map[i] && (half_ms[i] == '0 || blink_ph[i])) lit[i] = 1'b1;
    end
    if (!cfg_high) lit = ~lit;
    r.pin_levels = lit & LED_BITS;
    if (taken) begin
      r.status_valid = 1'b1;
      r.status_frame = cfg_stat_id;
      r.status_node = cfg_node;
      r.status_bitmap = on_map;
    end
    return r;
  endfunction

  task automatic flag(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
  endtask

  // ---------------------------------------------------------------------------
  // sender: called and returns at a falling edge; random gaps before the beat,
  // valid held until the beat is taken
  // ---------------------------------------------------------------------------
  task automatic send_item(in_t b, logic typed = 1'b0, out_t want = '0);
    out_t guess;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = b;
    do @(posedge clk_i); while (in_stall_o);
    // beat taken at this edge, model advances in step
    guess = step_leds(b);
    due_replies.push_back(typed ? want : guess);
    @(negedge clk_i);
  endtask

  // wait until every result beat is back, then keep the input idle a while longer
  task automatic drain;
    in_valid_i = 1'b0;
    while (due_replies.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NODE_ADDR:   cfg_node = val[7:0];
      CFG_BCAST_ADDR:  cfg_bcast = val[7:0];
      CFG_CMD_ID:      cfg_cmd_id = val[10:0];
      CFG_STATUS_ID:   cfg_stat_id = val[10:0];
      CFG_ACTIVE_HIGH: cfg_high = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // all five registers; unused upper data bits carry noise
  task automatic set_regs(logic [7:0] node, logic [7:0] bcast, logic [10:0] cid,
                          logic [10:0] sid, logic high);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_NODE_ADDR, {junk[10:8], node});
    write_reg(CFG_BCAST_ADDR, {junk[7:5], bcast});
    write_reg(CFG_CMD_ID, cid);
    write_reg(CFG_STATUS_ID, sid);
    write_reg(CFG_ACTIVE_HIGH, {junk[9:0], high});
  endtask

  // frame aimed at this node: mostly well formed, some noise and broken ones
  function automatic in_t make_frame();
    in_t         f;
    logic [63:0] raw;
    int          pick;
    raw = {$urandom, $urandom};
    f = raw[$bits(in_t)-1:0];
    f.command = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // pure noise
    end else if (pick < 18) begin
      // right identifier, too short
      f.frame_id = cfg_cmd_id;
      f.frame_len = 4'($urandom_range(0, MIN_FRAME_LEN - 1));
    end else begin
      f.frame_id = cfg_cmd_id;
      f.target_node = $urandom_range(0, 1) ? cfg_node : cfg_bcast;
      pick = $urandom_range(0, 99);
      f.frame_len = (pick < 20) ? 4'd3 :
                    (pick < 90) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
      // short periods so that toggles happen within a burst of ticks
      pick = $urandom_range(0, 99);
      f.flash_period = (pick < 60) ? 8'd1 :
                       (pick < 75) ? 8'd2 :
                       (pick < 85) ? 8'd0 : 8'($urandom);
    end
    return f;
  endfunction

  // a frame followed by a burst of ticks, repeated; tick payload is noise
  task automatic run_phase(int count);
    int          sent;
    int          burst;
    in_t         t;
    logic [63:0] raw;
    sent = 0;
    while (sent < count) begin
      send_item(make_frame());
      sent++;
      burst = $urandom_range(0, 110);
      // the last burst stops at the phase length
      if (burst > count - sent) burst = count - sent;
      repeat (burst) begin
        raw = {$urandom, $urandom};
        t = raw[$bits(in_t)-1:0];
        t.command = 1'b1;
        send_item(t);
      end
      sent += burst;
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls at the falling edge, checking at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 28);
  end

  always @(posedge clk_i) begin : check_replies
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_replies.size() == 0) begin
        flag($sformatf("result beat with nothing expected: %h", out_data_o));
      end else begin
        want = due_replies.pop_front();
        compare_field("pin_levels", want.pin_levels, out_data_o.pin_levels);
        compare_field("status_valid", want.status_valid, out_data_o.status_valid);
        compare_field("status_frame", want.status_frame, out_data_o.status_frame);
        compare_field("status_node", want.status_node, out_data_o.status_node);
        compare_field("status_bitmap", want.status_bitmap, out_data_o.status_bitmap);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_NODE_ADDR;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at reset register values
    for (int k = 0; k < PLAN_LEN; k++) begin
      send_item(PLAN[k].beat, PLAN[k].typed, PLAN[k].want);
    end
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        // low extremes: node equals broadcast, inverted drive
        0: set_regs(8'h00, 8'h00, 11'h000, 11'h000, 1'b0);
        // high extremes
        1: set_regs(8'hff, 8'hff, 11'h7ff, 11'h7ff, 1'b1);
        2: set_regs(8'($urandom), 8'($urandom), 11'($urandom), 11'($urandom), 1'b0);
        3: set_regs(8'($urandom), 8'($urandom), 11'($urandom), 11'($urandom), 1'b1);
        4: set_regs(8'hff, 8'h00, 11'h555, 11'h2aa, 1'b0);
        default: set_regs(8'($urandom), 8'($urandom), 11'($urandom), 11'($urandom),
                          1'($urandom));
      endcase
      // one whole phase with no gaps and no stalls
      calm = (ph == 2);
      run_phase(PHASE_ITEMS);
      drain();
      calm = 1'b0;
    end

    // let any stray beat show up before the verdict
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_replies.size() == 0) begin
      $display("tb_multi_led_flash_controller_unit: clean");
    end else begin
      $display("tb_multi_led_flash_controller_unit: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_multi_led_flash_controller_unit: errors");
    $finish;
  end

endmodule
